[src/akd_pkg.sv]
// ----------------------------------------------------------------------------
// akd_pkg: shared types and constants for the Annex-B keyframe detector
// Payload types, NAL type codes and the header classification function.
// ----------------------------------------------------------------------------
package akd_pkg;

  typedef logic [7:0] data_byte_t;
  typedef logic [1:0] zero_run_t;

  // codec selection held in the configuration register
  typedef enum logic {
    CODEC_H264 = 1'b0,
    CODEC_H265 = 1'b1
  } codec_mode_t;

  // nal type field masks
  localparam logic [4:0] H264_TYPE_MASK = 5'h1F;
  localparam logic [5:0] H265_TYPE_MASK = 6'h3F;

  // h.264 nal types that allow decoding to start
  localparam logic [4:0] H264_NAL_IDR = 5'd5;
  localparam logic [4:0] H264_NAL_SPS = 5'd7;
  localparam logic [4:0] H264_NAL_PPS = 5'd8;

  // h.265 nal types that allow decoding to start
  localparam logic [5:0] H265_NAL_VPS       = 6'd32;
  localparam logic [5:0] H265_NAL_SPS       = 6'd33;
  localparam logic [5:0] H265_NAL_PPS       = 6'd34;
  localparam logic [5:0] H265_NAL_IRAP_LOW  = 6'd16;
  localparam logic [5:0] H265_NAL_IRAP_HIGH = 6'd21;

  // zero run saturates once a start code prefix is complete
  localparam zero_run_t ZERO_RUN_PREFIX = 2'd2;
  localparam data_byte_t START_CODE_ONE = 8'h01;
  localparam data_byte_t ZERO_BYTE      = 8'h00;

  // true when a nal header byte marks a random-access point or parameter set
  function automatic logic header_qualifies(input codec_mode_t mode, input data_byte_t hdr);
    logic [4:0] t264;
    logic [5:0] t265;
    logic       hit;
    t264 = hdr[4:0] & H264_TYPE_MASK;
    t265 = hdr[6:1] & H265_TYPE_MASK;
    case (mode)
      CODEC_H265: begin
        hit = (t265 == H265_NAL_VPS) || (t265 == H265_NAL_SPS) ||
              (t265 == H265_NAL_PPS) ||
              ((t265 >= H265_NAL_IRAP_LOW) && (t265 <= H265_NAL_IRAP_HIGH));
      end
      default: begin
        hit = (t264 == H264_NAL_IDR) || (t264 == H264_NAL_SPS) ||
              (t264 == H264_NAL_PPS);
      end
    endcase
    return hit;
  endfunction

endpackage

[src/akd_if.sv]
// ----------------------------------------------------------------------------
// akd channel interfaces
// Valid/ready channels for byte input, unit results and configuration.
// ----------------------------------------------------------------------------

// byte input channel
interface akd_in_if
  import akd_pkg::*;
();
  logic       valid;
  logic       ready;
  data_byte_t data_byte;
  logic       unit_last;
  logic       rearm_wait;

  modport source (output valid, output data_byte, output unit_last, output rearm_wait,
                  input ready);
  modport sink (input valid, input data_byte, input unit_last, input rearm_wait,
                output ready);
endinterface

// per-unit result channel
interface akd_out_if
  import akd_pkg::*;
();
  logic valid;
  logic ready;
  logic can_start;
  logic forward_unit;

  modport source (output valid, output can_start, output forward_unit, input ready);
  modport sink (input valid, input can_start, input forward_unit, output ready);
endinterface

// configuration write channel
interface akd_cfg_if
  import akd_pkg::*;
();
  logic        valid;
  logic        ready;
  codec_mode_t codec_mode;

  modport source (output valid, output codec_mode, input ready);
  modport sink (input valid, input codec_mode, output ready);
endinterface

[src/annexb_keyframe_detector_top.sv]
// ----------------------------------------------------------------------------
// annexb_keyframe_detector_top: Annex-B start code and keyframe gate
// Scans access units byte by byte and reports one result per unit.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   - one beat per stream byte; unit_last marks the last byte of an
//             access unit, rearm_wait on a unit's first byte re-arms the gate.
//   results - one beat per access unit: can_start (parameter set or
//             random-access nal seen) and forward_unit (passes the gate).
//   cfg     - one beat writes codec_mode (0 h.264, 1 h.265); always ready;
//             users write only with no unit in flight; block does not enforce.
// Throughput is one byte per cycle while no last byte waits for a full result
// register: the start code scan state is a two-bit zero counter and a few
// flags updated once per byte. The last byte of a unit is scanned in the input
// register and its result is registered in the result register as it leaves;
// a pending result that stalls can hold it in the input register.
// Reset clears the scan, arms the keyframe gate and selects h.264.
// When results stalls, the pending result holds and the next unit's bytes
// keep flowing until its own last byte needs the result register.
// ----------------------------------------------------------------------------
module annexb_keyframe_detector_top
  import akd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  akd_in_if.sink    bytes,
  akd_out_if.source results,
  akd_cfg_if.sink   cfg
);

  // configuration register
  codec_mode_t codec_mode;

  // input register
  logic       s1_valid;
  data_byte_t s1_byte;
  logic       s1_last;
  logic       s1_rearm;
  logic       s1_go;

  // scan and gate state
  zero_run_t zero_run, zero_run_next;
  logic      header_next, header_next_next;
  logic      found_key, found_key_next;
  logic      at_unit_start, at_unit_start_next;
  logic      waiting_keyframe, waiting_keyframe_next;

  // result register
  logic out_valid;
  logic out_can, out_fwd;
  logic can_next, fwd_next;
  logic wait_eff;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode <= CODEC_H264;
    end else if (cfg.valid) begin
      codec_mode <= cfg.codec_mode;
    end
  end

  // input register advance: a last byte needs a free result slot
  assign s1_go       = s1_valid && (!s1_last || !out_valid || results.ready);
  assign bytes.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      s1_byte  <= bytes.data_byte;
      s1_last  <= bytes.unit_last;
      s1_rearm <= bytes.rearm_wait;
    end
  end

  // start code scan, header classification and gate decision
  always_comb begin
    wait_eff              = waiting_keyframe || (at_unit_start && s1_rearm);
    zero_run_next         = zero_run;
    header_next_next      = header_next;
    found_key_next        = found_key;
    at_unit_start_next    = 1'b0;
    waiting_keyframe_next = wait_eff;

    if (header_next) begin
      if (header_qualifies(codec_mode, s1_byte)) begin
        found_key_next = 1'b1;
      end
      header_next_next = 1'b0;
      zero_run_next    = '0;
    end else if (s1_byte == ZERO_BYTE) begin
      if (zero_run < ZERO_RUN_PREFIX) begin
        zero_run_next = zero_run + 2'd1;
      end
    end else begin
      if ((s1_byte == START_CODE_ONE) && (zero_run >= ZERO_RUN_PREFIX)) begin
        header_next_next = 1'b1;
      end
      zero_run_next = '0;
    end

    can_next = found_key_next;
    fwd_next = !wait_eff || found_key_next;

    // unit end: gate update and scan clear
    if (s1_last) begin
      waiting_keyframe_next = wait_eff && !found_key_next;
      zero_run_next         = '0;
      header_next_next      = 1'b0;
      found_key_next        = 1'b0;
      at_unit_start_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run         <= '0;
      header_next      <= 1'b0;
      found_key        <= 1'b0;
      at_unit_start    <= 1'b1;
      waiting_keyframe <= 1'b1;
    end else if (s1_go) begin
      zero_run         <= zero_run_next;
      header_next      <= header_next_next;
      found_key        <= found_key_next;
      at_unit_start    <= at_unit_start_next;
      waiting_keyframe <= waiting_keyframe_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      out_can <= can_next;
      out_fwd <= fwd_next;
    end
  end

  assign results.valid        = out_valid;
  assign results.can_start    = out_can;
  assign results.forward_unit = out_fwd;

  // a new result only follows a last byte leaving the input register
  a_result_from_last : assert property (@(posedge clk) disable iff (rst)
    (results.valid && !$past(results.valid)) |-> $past(s1_go && s1_last))
    else $error("result appeared without a unit end");

  // a unit that may start decoding always passes the gate
  a_can_forwards : assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.can_start) |-> results.forward_unit)
    else $error("keyframe unit was not forwarded");

  // a pending header byte never carries a zero count
  a_header_no_zeros : assert property (@(posedge clk) disable iff (rst)
    header_next |-> (zero_run == '0))
    else $error("header pending with nonzero zero run");

  // scan state is clean at the start of every unit
  a_unit_clear : assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (zero_run == '0 && !header_next && !found_key && at_unit_start))
    else $error("scan state not cleared after unit end");

endmodule
